// ===== sv/short_name_basis_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the short name basis generator
// Shared property wrappers; clocked on i_clk of the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef SHORT_NAME_BASIS_GENERATOR_CORE_DEFINES_SVH
`define SHORT_NAME_BASIS_GENERATOR_CORE_DEFINES_SVH

// Checked only while out of reset.
`define SBG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SBG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/sbg_pkg.sv =====
// ----------------------------------------------------------------------------
// sbg_pkg
// Types and constants shared by the short name basis generator modules.
// ----------------------------------------------------------------------------
package sbg_pkg;

    localparam int MAX_NAME_BYTES = 256;
    localparam int BYTE_CNT_W     = $clog2(MAX_NAME_BYTES + 2);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    localparam logic [8*BASE_LEN-1:0] BASE_BLANK = {BASE_LEN{CHAR_SPACE}};
    localparam logic [8*EXT_LEN-1:0]  EXT_BLANK  = {EXT_LEN{CHAR_SPACE}};

    localparam logic [1:0] STATUS_EXACT  = 2'd0;
    localparam logic [1:0] STATUS_LOSSY  = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,   // skipping leading dots
        PH_BASE = 2'd1,
        PH_EXT  = 2'd2
    } t_phase;

    // One classified input beat.
    typedef struct packed {
        logic [7:0] ch;        // upper-cased, legalized character
        logic       is_dot;
        logic       is_space;
        logic       case_chg;  // byte was lower case
        logic       bad;       // replaced by underscore
        logic       reject;    // reserved path character
        logic       is_end;
    } t_item;

endpackage

// ===== sv/short_name_basis_generator_core.sv =====
// A result is registered in the back end once its end record leaves the queue and the output register is free.
// Throughput: one name byte per cycle while the queue has room; an end beat waits while the output holds a result.
// The rate is set by the combinational classify step in the front and the update step in the back end.
// A 4-entry queue lets the input keep streaming while a result waits on m_axis_tready.
// Reset: synchronous, active low; clears the queue, the name state and the output valid.
// ----------------------------------------------------------------------------
// short_name_basis_generator_core
// Streams a long file name in byte beats and emits its 8.3 basis name.
// ----------------------------------------------------------------------------
module short_name_basis_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // name byte stream; tlast marks the end beat (its tdata is ignored)
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] name_byte
    input  logic        s_axis_tlast,   // end_of_name

    // one result beat per name
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [63:0] base_name, [87:64] extension
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    sbg_pkg::t_item front_item;
    sbg_pkg::t_item q_item;
    logic           q_valid;
    logic           q_ready;

    // Front: byte classification, no state.
    sbg_front u_front (
        .i_byte (s_axis_tdata),
        .i_end  (s_axis_tlast),
        .o_item (front_item)
    );

    // Queue decouples input stalls from output back-pressure.
    sbg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (s_axis_tvalid),
        .o_wr_ready (s_axis_tready),
        .i_wr_item  (front_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    // Back: name assembly and the result register.
    sbg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (q_valid),
        .o_rd_ready (q_ready),
        .i_rd_item  (q_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_base     (m_axis_tdata[63:0]),
        .o_ext      (m_axis_tdata[87:64]),
        .o_status   (m_axis_tuser)
    );

endmodule

// ===== sv/sbg_front.sv =====
// ----------------------------------------------------------------------------
// sbg_front
// Classifies each incoming name byte into a queue record.
// ----------------------------------------------------------------------------
module sbg_front (
    input  logic          [7:0] i_byte,
    input  logic                i_end,
    output sbg_pkg::t_item      o_item
);

    logic [7:0] upper;
    logic       is_lower;
    logic       in_bad_set;
    logic       in_rej_set;

    always_comb begin
        is_lower = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
        upper    = is_lower ? (i_byte - 8'h20) : i_byte;

        case (upper)
            8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C,
            8'h3D, 8'h3E, 8'h3F, 8'h5C, 8'h5B, 8'h5D, 8'h7C: begin
                in_bad_set = 1'b1;
            end
            default: begin
                in_bad_set = 1'b0;
            end
        endcase

        // \ / : * ? " < > |
        case (i_byte)
            8'h5C, 8'h2F, 8'h3A, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E, 8'h7C: begin
                in_rej_set = 1'b1;
            end
            default: begin
                in_rej_set = 1'b0;
            end
        endcase

        o_item.bad      = (upper < 8'h20) || (upper >= 8'h7F) || in_bad_set;
        o_item.ch       = o_item.bad ? sbg_pkg::CHAR_UNDER : upper;
        o_item.is_dot   = (i_byte == sbg_pkg::CHAR_DOT);
        o_item.is_space = (i_byte == sbg_pkg::CHAR_SPACE);
        o_item.case_chg = is_lower;
        o_item.reject   = in_rej_set;
        o_item.is_end   = i_end;
    end

endmodule

// ===== sv/sbg_queue.sv =====
// ----------------------------------------------------------------------------
// sbg_queue
// Short FIFO of classified records between front and back.
// ----------------------------------------------------------------------------
module sbg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  sbg_pkg::t_item i_wr_item,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output sbg_pkg::t_item o_rd_item
);

    sbg_pkg::t_item                     r_mem [sbg_pkg::Q_DEPTH];
    logic [sbg_pkg::Q_PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [sbg_pkg::Q_PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [sbg_pkg::Q_CNT_W-1:0]        r_count, n_count;
    logic                               push, pop;

    localparam logic [sbg_pkg::Q_PTR_W-1:0] PTR_LAST = sbg_pkg::Q_PTR_W'(sbg_pkg::Q_DEPTH - 1);
    localparam logic [sbg_pkg::Q_CNT_W-1:0] CNT_FULL = sbg_pkg::Q_CNT_W'(sbg_pkg::Q_DEPTH);

    assign o_wr_ready = (r_count != CNT_FULL);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

// ===== sv/sbg_back.sv =====
// ----------------------------------------------------------------------------
// sbg_back
// Builds the 8.3 name from queued records and registers the result.
// ----------------------------------------------------------------------------
module sbg_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_valid,
    output logic                                o_rd_ready,
    input  sbg_pkg::t_item                      i_rd_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [8*sbg_pkg::BASE_LEN-1:0]      o_base,
    output logic [8*sbg_pkg::EXT_LEN-1:0]       o_ext,
    output logic [1:0]                          o_status
);

    sbg_pkg::t_phase                     r_phase, n_phase;
    logic [8*sbg_pkg::BASE_LEN-1:0]      r_base, n_base;
    logic [3:0]                          r_base_cnt, n_base_cnt;
    logic [8*sbg_pkg::EXT_LEN-1:0]       r_ext, n_ext;
    logic [1:0]                          r_ext_slots, n_ext_slots;
    logic [1:0]                          r_ext_wr, n_ext_wr;
    logic [1:0]                          r_dots, n_dots;
    logic                                r_lossy, n_lossy;
    logic                                r_reject, n_reject;
    logic [sbg_pkg::BYTE_CNT_W-1:0]      r_byte_cnt, n_byte_cnt;

    logic                                r_out_valid, n_out_valid;
    logic [8*sbg_pkg::BASE_LEN-1:0]      r_out_base, n_out_base;
    logic [8*sbg_pkg::EXT_LEN-1:0]       r_out_ext, n_out_ext;
    logic [1:0]                          r_out_status, n_out_status;

    logic                                pop;
    logic                                do_base;
    sbg_pkg::t_item                      it;

    localparam logic [sbg_pkg::BYTE_CNT_W-1:0] BYTE_MAX =
        sbg_pkg::BYTE_CNT_W'(sbg_pkg::MAX_NAME_BYTES);

    assign it         = i_rd_item;
    // End records wait for a free output register; name bytes never do.
    assign o_rd_ready = !it.is_end || !r_out_valid || i_ready;
    assign pop        = i_rd_valid && o_rd_ready;

    assign o_valid  = r_out_valid;
    assign o_base   = r_out_base;
    assign o_ext    = r_out_ext;
    assign o_status = r_out_status;

    always_comb begin
        n_phase      = r_phase;
        n_base       = r_base;
        n_base_cnt   = r_base_cnt;
        n_ext        = r_ext;
        n_ext_slots  = r_ext_slots;
        n_ext_wr     = r_ext_wr;
        n_dots       = r_dots;
        n_lossy      = r_lossy;
        n_reject     = r_reject;
        n_byte_cnt   = r_byte_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_base   = r_out_base;
        n_out_ext    = r_out_ext;
        n_out_status = r_out_status;
        do_base      = 1'b0;

        if (pop && it.is_end) begin
            n_out_valid = 1'b1;
            if (r_reject) begin
                n_out_base   = '0;
                n_out_ext    = '0;
                n_out_status = sbg_pkg::STATUS_REJECT;
            end else begin
                n_out_base   = r_base;
                n_out_ext    = r_ext;
                n_out_status = r_lossy ? sbg_pkg::STATUS_LOSSY : sbg_pkg::STATUS_EXACT;
            end
            n_phase     = sbg_pkg::PH_LEAD;
            n_base      = sbg_pkg::BASE_BLANK;
            n_base_cnt  = '0;
            n_ext       = sbg_pkg::EXT_BLANK;
            n_ext_slots = '0;
            n_ext_wr    = '0;
            n_dots      = '0;
            n_lossy     = 1'b0;
            n_reject    = 1'b0;
            n_byte_cnt  = '0;
        end else if (pop) begin
            // length check saturates one past the limit
            if (r_byte_cnt <= BYTE_MAX) begin
                n_byte_cnt = r_byte_cnt + 1'b1;
            end
            if (n_byte_cnt > BYTE_MAX || it.reject) begin
                n_reject = 1'b1;
            end

            case (r_phase)
                sbg_pkg::PH_LEAD: begin
                    if (it.is_dot) begin
                        n_lossy = 1'b1;
                    end else begin
                        n_phase = sbg_pkg::PH_BASE;
                        do_base = 1'b1;
                    end
                end
                sbg_pkg::PH_BASE: begin
                    do_base = 1'b1;
                end
                default: begin
                    // extension; a later dot restarts it
                    if (it.is_dot) begin
                        n_dots = (r_dots < 2'd2) ? r_dots + 1'b1 : r_dots;
                        if (n_dots >= 2'd2) begin
                            n_lossy = 1'b1;
                        end
                        n_ext       = sbg_pkg::EXT_BLANK;
                        n_ext_slots = '0;
                        n_ext_wr    = '0;
                    end else if (r_ext_slots >= 2'(sbg_pkg::EXT_LEN)) begin
                        n_lossy = 1'b1;
                    end else begin
                        n_ext_slots = r_ext_slots + 1'b1;
                        if (it.is_space) begin
                            n_lossy = 1'b1;
                        end else begin
                            n_lossy = r_lossy || it.bad;
                            if (r_ext_wr < 2'(sbg_pkg::EXT_LEN)) begin
                                for (int i = 0; i < sbg_pkg::EXT_LEN; i++) begin
                                    if (r_ext_wr == 2'(i)) begin
                                        n_ext[8*(sbg_pkg::EXT_LEN-1-i) +: 8] = it.ch;
                                    end
                                end
                                n_ext_wr = r_ext_wr + 1'b1;
                            end
                        end
                    end
                end
            endcase

            if (do_base) begin
                if (it.is_dot) begin
                    n_phase = sbg_pkg::PH_EXT;
                    n_dots  = 2'd1;
                end else if (r_base_cnt >= 4'(sbg_pkg::BASE_LEN)) begin
                    n_lossy = 1'b1;
                end else if (it.is_space) begin
                    n_lossy = 1'b1;
                end else begin
                    n_lossy = n_lossy || it.case_chg || it.bad;
                    for (int i = 0; i < sbg_pkg::BASE_LEN; i++) begin
                        if (r_base_cnt[2:0] == 3'(i)) begin
                            n_base[8*(sbg_pkg::BASE_LEN-1-i) +: 8] = it.ch;
                        end
                    end
                    n_base_cnt = r_base_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sbg_pkg::PH_LEAD;
            r_base      <= sbg_pkg::BASE_BLANK;
            r_base_cnt  <= '0;
            r_ext       <= sbg_pkg::EXT_BLANK;
            r_ext_slots <= '0;
            r_ext_wr    <= '0;
            r_dots      <= '0;
            r_lossy     <= 1'b0;
            r_reject    <= 1'b0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_base_cnt  <= n_base_cnt;
            r_ext       <= n_ext;
            r_ext_slots <= n_ext_slots;
            r_ext_wr    <= n_ext_wr;
            r_dots      <= n_dots;
            r_lossy     <= n_lossy;
            r_reject    <= n_reject;
            r_byte_cnt  <= n_byte_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_base   <= n_out_base;
        r_out_ext    <= n_out_ext;
        r_out_status <= n_out_status;
    end

endmodule

// ===== sv/sbg_checker.sv =====
// ----------------------------------------------------------------------------
// sbg_checker
// Port-level checks on the short name basis generator, bound to the top.
// ----------------------------------------------------------------------------
`include "short_name_basis_generator_core_defines.svh"

module sbg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result beat holds
    `SBG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // rejected names carry all-zero fields
    `SBG_ASSERT(a_reject_zero, m_axis_tvalid && (m_axis_tuser == sbg_pkg::STATUS_REJECT) |-> (m_axis_tdata == '0), "rejected result has nonzero name")

    // reset leaves no result pending
    `SBG_ASSERT_ALWAYS(a_rst_out_idle, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

    // queue is empty after reset, so input is open
    `SBG_ASSERT_ALWAYS(a_rst_in_ready, !i_rst_n |=> s_axis_tready, "input not ready right after reset")

endmodule

bind short_name_basis_generator_core sbg_checker u_sbg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
